// File: design/pac_pkg.sv
// Shared widths, register codes and interface types for the PID angle controller.
// Used by pac_regs, pac_div and pid_angle_controller; depends on nothing.
`default_nettype none

package pac_pkg;

  localparam int GainW   = 16;
  localparam int AngleW  = 16;
  localparam int ErrW    = 17;
  localparam int DiffW   = 18;
  localparam int ProdW   = 34;
  localparam int TimeW   = 32;
  localparam int DriveW  = 32;
  localparam int QShift  = 8;
  localparam int TermW   = ProdW - QShift;
  localparam int DivNumW = TermW;
  localparam int DivCntW = $clog2(DivNumW);
  localparam int AddrW   = 4;
  localparam int DataW   = 32;
  localparam int IdxW    = 2;

  localparam logic [IdxW-1:0] RegGainProp  = 2'd0;
  localparam logic [IdxW-1:0] RegGainInteg = 2'd1;
  localparam logic [IdxW-1:0] RegGainDeriv = 2'd2;

  localparam logic [GainW-1:0] GainPropRst  = 16'd256;
  localparam logic [GainW-1:0] GainIntegRst = 16'd0;
  localparam logic [GainW-1:0] GainDerivRst = 16'd0;

  typedef struct packed {
    logic signed [GainW-1:0] prop;
    logic signed [GainW-1:0] integ;
    logic signed [GainW-1:0] deriv;
  } gains_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: design/pid_angle_controller.sv
// PID angle controller: error = measured - target, drive = P + saturating I + D, Q8.8.
// Each beat passes through PROP, INTEG, DERIV, DSTART, DIV, SUM and OUT; DIV, the
// 26-step bit-serial divider for the derivative term, is skipped at zero elapsed time.
// A new beat is taken only in IDLE, once the last result is loaded for output; the shared
// multiplier forms the three products one after another. Reset clears gains to
// P = 1.0, I = D = 0, and integral, last error and last time to zero.
`default_nettype none

module pid_angle_controller (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic        [pac_pkg::AddrW-1:0] paddr,
  input  wire logic        [pac_pkg::DataW-1:0] pwdata,
  output logic             [pac_pkg::DataW-1:0] prdata,
  output logic                                  pready,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic signed [pac_pkg::AngleW-1:0] measured_angle_i,
  input  wire logic signed [pac_pkg::AngleW-1:0] target_angle_i,
  input  wire logic        [pac_pkg::TimeW-1:0]  now_ms_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed      [pac_pkg::DriveW-1:0] drive_o,
  output logic                                  saturated_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PROP   = 3'd1;
  localparam logic [2:0] S_INTEG  = 3'd2;
  localparam logic [2:0] S_DERIV  = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_SUM    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  localparam int SumW = pac_pkg::ProdW;
  localparam int AccW = pac_pkg::DriveW + 1;
  localparam int DW   = pac_pkg::DivNumW + 1;

  localparam logic signed [pac_pkg::DriveW-1:0] DriveMax = {1'b0, {(pac_pkg::DriveW-1){1'b1}}};
  localparam logic signed [pac_pkg::DriveW-1:0] DriveMin = {1'b1, {(pac_pkg::DriveW-1){1'b0}}};

  pac_pkg::gains_t    gains;
  pac_pkg::div_stat_t div_stat;

  logic [2:0]                          state_q, state_d;
  logic signed [pac_pkg::ErrW-1:0]     err_q;
  logic signed [pac_pkg::ErrW-1:0]     last_err_q;
  logic [pac_pkg::TimeW-1:0]           last_time_q;
  logic [pac_pkg::TimeW-1:0]           now_q;
  logic [pac_pkg::TimeW-1:0]           elapsed_q;
  logic signed [pac_pkg::ProdW-1:0]    prod_q;
  logic signed [pac_pkg::TermW-1:0]    p_q;
  logic signed [pac_pkg::DriveW-1:0]   integ_q;
  logic signed [DW-1:0]                d_q;
  logic signed [SumW-1:0]              sum_q;
  logic                                hit_q;
  logic                                neg_q;
  logic                                out_valid_q;
  logic signed [pac_pkg::DriveW-1:0]   drive_q;
  logic                                sat_q;

  logic signed [pac_pkg::GainW-1:0]    mul_a;
  logic signed [pac_pkg::DiffW-1:0]    mul_b;
  logic signed [pac_pkg::ProdW-1:0]    prod_c;
  logic signed [pac_pkg::TermW-1:0]    prod_sh;
  logic signed [AccW-1:0]              acc_c;
  logic                                acc_ovf;
  logic [pac_pkg::ProdW-1:0]           mag_c;
  logic [pac_pkg::DivNumW-1:0]         quotient;
  logic                                div_start;
  logic                                in_beat;
  logic                                out_load;
  logic                                sum_ovf;

  pac_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains_o (gains)
  );

  pac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_c[pac_pkg::ProdW-1:pac_pkg::QShift]),
    .divisor_i  (elapsed_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign div_start  = (state_q == S_DSTART) && (elapsed_q != '0);

  always_comb begin
    case (state_q)
      S_PROP:  mul_a = gains.prop;
      S_INTEG: mul_a = gains.integ;
      default: mul_a = gains.deriv;
    endcase
    if (state_q == S_DERIV) begin
      mul_b = pac_pkg::DiffW'(err_q) - pac_pkg::DiffW'(last_err_q);
    end else begin
      mul_b = pac_pkg::DiffW'(err_q);
    end
  end

  assign prod_c  = pac_pkg::ProdW'(mul_a) * pac_pkg::ProdW'(mul_b);
  assign prod_sh = prod_q[pac_pkg::ProdW-1:pac_pkg::QShift];
  assign acc_c   = AccW'(integ_q) + AccW'(prod_sh);
  assign acc_ovf = acc_c[AccW-1] != acc_c[AccW-2];
  assign mag_c   = prod_q[pac_pkg::ProdW-1] ? pac_pkg::ProdW'(-prod_q) : prod_q;
  assign sum_ovf = !((sum_q[SumW-1:pac_pkg::DriveW-1] == '0) ||
                     (sum_q[SumW-1:pac_pkg::DriveW-1] == '1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_beat) state_d = S_PROP;
      S_PROP:   state_d = S_INTEG;
      S_INTEG:  state_d = S_DERIV;
      S_DERIV:  state_d = S_DSTART;
      S_DSTART: state_d = div_start ? S_DIV : S_SUM;
      S_DIV:    if (div_stat.done) state_d = S_SUM;
      S_SUM:    state_d = S_OUT;
      S_OUT:    if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      last_err_q  <= '0;
      last_time_q <= '0;
      hit_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_beat) begin
        hit_q <= 1'b0;
      end
      if (state_q == S_DERIV) begin
        if (acc_ovf) begin
          integ_q <= acc_c[AccW-1] ? DriveMin : DriveMax;
          hit_q   <= 1'b1;
        end else begin
          integ_q <= acc_c[pac_pkg::DriveW-1:0];
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        last_err_q  <= err_q;
        last_time_q <= now_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      err_q     <= pac_pkg::ErrW'(measured_angle_i) - pac_pkg::ErrW'(target_angle_i);
      now_q     <= now_ms_i;
      elapsed_q <= now_ms_i - last_time_q;
    end
    if (state_q == S_PROP || state_q == S_INTEG || state_q == S_DERIV) begin
      prod_q <= prod_c;
    end
    if (state_q == S_INTEG) begin
      p_q <= prod_sh;
    end
    if (state_q == S_DSTART) begin
      neg_q <= prod_q[pac_pkg::ProdW-1];
      if (!div_start) begin
        d_q <= '0;
      end
    end
    if (state_q == S_DIV && div_stat.done) begin
      d_q <= neg_q ? -DW'(quotient) : DW'(quotient);
    end
    if (state_q == S_SUM) begin
      sum_q <= SumW'(p_q) + SumW'(integ_q) + SumW'(d_q);
    end
    if (out_load) begin
      if (sum_ovf) begin
        drive_q <= sum_q[SumW-1] ? DriveMin : DriveMax;
      end else begin
        drive_q <= sum_q[pac_pkg::DriveW-1:0];
      end
      sat_q <= hit_q || sum_ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign saturated_o = sat_q;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  a_zero_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DSTART && elapsed_q == '0) |=> (state_q == S_SUM && d_q == '0))
    else $error("derivative not skipped for zero elapsed time");

endmodule

`default_nettype wire

// File: design/pac_regs.sv
// APB-style gain register file for the PID angle controller.
// Depends on pac_pkg for widths, register codes and the gains_t bundle.
`default_nettype none

module pac_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [pac_pkg::AddrW-1:0] paddr,
  input  wire logic [pac_pkg::DataW-1:0] pwdata,
  output logic      [pac_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output pac_pkg::gains_t                gains_o
);

  pac_pkg::gains_t                gains_q;
  logic [pac_pkg::IdxW-1:0]       idx;
  logic                           wr_en;

  assign idx    = paddr[pac_pkg::AddrW-1:pac_pkg::AddrW-pac_pkg::IdxW];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign gains_o = gains_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.prop  <= pac_pkg::GainPropRst;
      gains_q.integ <= pac_pkg::GainIntegRst;
      gains_q.deriv <= pac_pkg::GainDerivRst;
    end else if (wr_en) begin
      case (idx)
        pac_pkg::RegGainProp:  gains_q.prop  <= pwdata[pac_pkg::GainW-1:0];
        pac_pkg::RegGainInteg: gains_q.integ <= pwdata[pac_pkg::GainW-1:0];
        pac_pkg::RegGainDeriv: gains_q.deriv <= pwdata[pac_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pac_pkg::RegGainProp:  prdata = pac_pkg::DataW'(gains_q.prop);
      pac_pkg::RegGainInteg: prdata = pac_pkg::DataW'(gains_q.integ);
      pac_pkg::RegGainDeriv: prdata = pac_pkg::DataW'(gains_q.deriv);
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/pac_div.sv
// Restoring unsigned divider, one quotient bit per cycle, for the derivative term.
// Depends on pac_pkg for operand widths and the div_stat_t status bundle.
`default_nettype none

module pac_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [pac_pkg::DivNumW-1:0] dividend_i,
  input  wire logic [pac_pkg::TimeW-1:0]   divisor_i,
  output logic      [pac_pkg::DivNumW-1:0] quotient_o,
  output pac_pkg::div_stat_t               stat_o
);

  logic [pac_pkg::TimeW-1:0]   rem_q;
  logic [pac_pkg::DivNumW-1:0] quo_q;
  logic [pac_pkg::TimeW-1:0]   dvs_q;
  logic [pac_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q;
  logic                        done_q;
  logic [pac_pkg::TimeW:0]     trial;
  logic [pac_pkg::TimeW:0]     diff;
  logic                        ge;

  assign trial = {rem_q, quo_q[pac_pkg::DivNumW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == pac_pkg::DivCntW'(pac_pkg::DivNumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[pac_pkg::TimeW-1:0] : trial[pac_pkg::TimeW-1:0];
      quo_q <= {quo_q[pac_pkg::DivNumW-2:0], ge};
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// File: sim/pac_drive_checker.sv
`timescale 1ns / 100ps
// Scoreboard for pid_angle_controller: snoops register writes and both beat channels,
// predicts drive and the clip flag per input beat, and compares result beats in order.
// Depends on pac_pkg for widths and register codes.

module pac_drive_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic        [pac_pkg::AddrW-1:0]  paddr,
  input  logic        [pac_pkg::DataW-1:0]  pwdata,
  input  logic                              pready,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [pac_pkg::AngleW-1:0] measured_angle_i,
  input  logic signed [pac_pkg::AngleW-1:0] target_angle_i,
  input  logic        [pac_pkg::TimeW-1:0]  now_ms_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [pac_pkg::DriveW-1:0] drive_i,
  input  logic                              saturated_i,
  output int                                mismatches_o,
  output int                                pending_o,
  output int                                results_o,
  output int                                clipped_o
);

  localparam longint DriveMax = (longint'(1) <<< (pac_pkg::DriveW - 1)) - 1;
  localparam longint DriveMin = -DriveMax - 1;

  typedef struct packed {
    logic signed [pac_pkg::DriveW-1:0] drive;
    logic                              clipped;
  } drive_beat_t;

  logic signed [pac_pkg::GainW-1:0] kp, ki, kd;
  longint                           integ;
  longint                           prev_err;
  logic        [pac_pkg::TimeW-1:0] prev_time;
  drive_beat_t                      drive_expected[$];
  drive_beat_t                      want;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    results_o    = 0;
    clipped_o    = 0;
  end

  function automatic longint clip32(longint v);
    if (v > DriveMax) return DriveMax;
    if (v < DriveMin) return DriveMin;
    return v;
  endfunction

  function automatic drive_beat_t step_controller(logic signed [pac_pkg::AngleW-1:0] meas,
                                                  logic signed [pac_pkg::AngleW-1:0] targ,
                                                  logic [pac_pkg::TimeW-1:0] now);
    longint                      err, prop, deriv, sum;
    logic [pac_pkg::TimeW-1:0]   elapsed;
    drive_beat_t                 beat;
    err = longint'(meas) - longint'(targ);
    prop = (longint'(kp) * err) >>> pac_pkg::QShift;
    sum = integ + ((longint'(ki) * err) >>> pac_pkg::QShift);
    integ = clip32(sum);
    beat.clipped = (sum != integ);
    elapsed = now - prev_time;
    deriv = 0;
    if (elapsed != 0) begin
      deriv = (longint'(kd) * (err - prev_err)) / (longint'(elapsed) <<< pac_pkg::QShift);
    end
    sum = prop + integ + deriv;
    beat.drive = pac_pkg::DriveW'(clip32(sum));
    beat.clipped = beat.clipped | (sum != clip32(sum));
    prev_err = err;
    prev_time = now;
    return beat;
  endfunction

  task automatic report_mismatch(input string what, input longint want_v, input longint got_v);
    $display("%0t: %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp = pac_pkg::GainPropRst;
      ki = pac_pkg::GainIntegRst;
      kd = pac_pkg::GainDerivRst;
      integ = 0;
      prev_err = 0;
      prev_time = '0;
      drive_expected.delete();
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[pac_pkg::AddrW-1:2])
          pac_pkg::RegGainProp: begin
            kp = pwdata[pac_pkg::GainW-1:0];
          end
          pac_pkg::RegGainInteg: begin
            ki = pwdata[pac_pkg::GainW-1:0];
          end
          pac_pkg::RegGainDeriv: begin
            kd = pwdata[pac_pkg::GainW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (drive_expected.size() == 0) begin
          report_mismatch("result beat with nothing pending, drive", 0, longint'(drive_i));
        end else begin
          want = drive_expected.pop_front();
          if (drive_i !== want.drive) begin
            report_mismatch("drive", longint'(want.drive), longint'(drive_i));
          end
          if (saturated_i !== want.clipped) begin
            report_mismatch("saturated", longint'(want.clipped), longint'(saturated_i));
          end
          results_o++;
          if (want.clipped) begin
            clipped_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        drive_expected.push_back(step_controller(measured_angle_i, target_angle_i, now_ms_i));
      end
      pending_o = drive_expected.size();
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Top of the pid_angle_controller bench: clock, reset, register writes, input beats
// and result back-pressure; pac_drive_checker does all prediction and comparison.
// Depends on pac_pkg, pid_angle_controller and pac_drive_checker.

module testbench;

  localparam int                       IdleLimit = 3000;
  localparam int                       TailWait  = 50;
  localparam logic [pac_pkg::IdxW-1:0] RegUnused = 2'd3;

  logic                              clk;
  logic                              rst_n;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic        [pac_pkg::AddrW-1:0]  paddr;
  logic        [pac_pkg::DataW-1:0]  pwdata;
  logic        [pac_pkg::DataW-1:0]  prdata;
  logic                              pready;
  logic                              in_valid;
  logic                              in_ready;
  logic signed [pac_pkg::AngleW-1:0] measured_angle;
  logic signed [pac_pkg::AngleW-1:0] target_angle;
  logic        [pac_pkg::TimeW-1:0]  now_ms;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [pac_pkg::DriveW-1:0] drive;
  logic                              saturated;

  int                                mismatches;
  int                                pending;
  int                                results;
  int                                clipped;
  int                                sent;
  int                                tx_idle_pct;
  int                                rx_idle_pct;
  int                                hold_left;
  int                                idle_cycles;
  logic        [pac_pkg::TimeW-1:0]  stamp;

  pid_angle_controller dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .measured_angle_i (measured_angle),
    .target_angle_i   (target_angle),
    .now_ms_i         (now_ms),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .drive_o          (drive),
    .saturated_o      (saturated)
  );

  pac_drive_checker drive_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .measured_angle_i (measured_angle),
    .target_angle_i   (target_angle),
    .now_ms_i         (now_ms),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .drive_i          (drive),
    .saturated_i      (saturated),
    .mismatches_o     (mismatches),
    .pending_o        (pending),
    .results_o        (results),
    .clipped_o        (clipped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    idle_cycles = 0;
    wait (idle_cycles >= IdleLimit);
    $display("watchdog: no beat accepted for %0d cycles, %0d results pending",
             IdleLimit, pending);
    $display("TB_ERROR");
    $finish;
  end

  // result side: long hold-off first, else random back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [pac_pkg::IdxW-1:0] idx,
                           input logic [pac_pkg::GainW-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = pac_pkg::AddrW'({idx, 2'b00});
    pwdata = {16'($urandom), value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic write_gains(input logic [pac_pkg::GainW-1:0] kp,
                             input logic [pac_pkg::GainW-1:0] ki,
                             input logic [pac_pkg::GainW-1:0] kd);
    write_reg(pac_pkg::RegGainProp, kp);
    write_reg(pac_pkg::RegGainInteg, ki);
    write_reg(pac_pkg::RegGainDeriv, kd);
  endtask

  task automatic send_beat(input logic [pac_pkg::AngleW-1:0] meas,
                           input logic [pac_pkg::AngleW-1:0] targ,
                           input logic [pac_pkg::TimeW-1:0] ms);
    int gap;
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 50);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    measured_angle = meas;
    target_angle = targ;
    now_ms = ms;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // drop valid and hold until every result is back
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
  endtask

  function automatic logic [pac_pkg::TimeW-1:0] advance_ms(logic [pac_pkg::TimeW-1:0] cur);
    case ($urandom_range(9))
      0, 1: return cur;
      2, 3, 4, 5: return cur + $urandom_range(1, 20);
      6, 7: return cur + $urandom_range(21, 5000);
      default: return $urandom();
    endcase
  endfunction

  // windup_pct of the beats carry a large positive error, the rest are noise
  task automatic send_random(input int count, input int windup_pct);
    logic [pac_pkg::AngleW-1:0] meas;
    logic [pac_pkg::AngleW-1:0] targ;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < windup_pct) begin
        meas = 16'h7fff - 16'($urandom_range(2767));
        targ = 16'h8000 + 16'($urandom_range(2767));
      end else begin
        meas = 16'($urandom());
        targ = 16'($urandom());
      end
      stamp = advance_ms(stamp);
      send_beat(meas, targ, stamp);
      if (i == 10 && windup_pct == 0) begin
        hold_left = 300;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    measured_angle = '0;
    target_angle = '0;
    now_ms = '0;
    sent = 0;
    hold_left = 0;
    stamp = '0;
    tx_idle_pct = 30;
    rx_idle_pct = 64;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_beat(16'h0000, 16'h0000, 32'd0);
    send_beat(16'h7fff, 16'h8000, 32'd1);
    send_beat(16'h8000, 16'h7fff, 32'd1);
    send_beat(16'h0001, 16'h0000, 32'd2);
    send_beat(16'hffff, 16'h0000, 32'd3);
    settle();

    write_gains(16'h7fff, 16'h8000, 16'h7fff);
    send_beat(16'h8000, 16'h7fff, 32'hffff_ffff);
    send_beat(16'h7fff, 16'h8000, 32'd0);
    send_beat(16'h7fff, 16'h7fff, 32'd0);
    send_beat(16'h0001, 16'h0000, 32'd1);
    send_beat(16'hffff, 16'h0000, 32'd4);
    send_beat(16'h0000, 16'h0000, 32'd7);
    settle();

    write_gains(16'h8000, 16'h7fff, 16'h8000);
    write_reg(RegUnused, 16'($urandom()));
    send_beat(16'h7fff, 16'h8000, 32'd100);
    send_beat(16'h8000, 16'h7fff, 32'd101);
    send_beat(16'h8000, 16'h8000, 32'd101);
    send_beat(16'h1234, 16'hedcc, 32'd1100);
    settle();

    write_gains(16'hffff, 16'h0001, 16'hffff);
    send_beat(16'h0003, 16'h0000, 32'd1103);
    send_beat(16'hffff, 16'h0002, 32'd1104);
    send_beat(16'h0100, 16'h0000, 32'd1200);
    send_beat(16'h0000, 16'h0100, 32'd1201);
    send_beat(16'h0000, 16'h0000, 32'd1201);
    settle();

    stamp = 32'd1201;
    write_gains(16'($urandom()), 16'($urandom()), 16'($urandom()));
    send_random(30, 0);
    settle();
    write_gains(16'($urandom()), 16'($urandom()), 16'($urandom()));
    send_random(30, 0);
    settle();

    // wind the integral up into its upper limit
    tx_idle_pct = 64;
    rx_idle_pct = 30;
    write_gains(16'($urandom_range(1, 32767)), 16'h7fff, 16'($urandom()));
    send_random(300, 95);
    settle();

    // then unwind it back down
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_gains(16'(-$urandom_range(1, 32768)), 16'h8000, 16'($urandom()));
    send_random(70, 95);
    settle();

    repeat (TailWait) @(posedge clk);
    $display("covered %0d input beats and %0d result beats, %0d of them clipped,",
             sent, results, clipped);
    $display("over eight gain settings, with stalls on both sides and integral windup");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/pac_pkg.sv
design/pac_regs.sv
design/pac_div.sv
design/pid_angle_controller.sv
sim/pac_drive_checker.sv
sim/testbench.sv
